// ===== rtl/srpb_pkg.sv =====
// Package for the shading ramp palette builder.
// Holds the command and status codes, widths and the result word type.
// No dependencies.
package srpb_pkg;
    localparam int ENTRIES = 256;
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_ADD   = 3'd1;
    localparam logic [2:0] FN_FIND  = 3'd2;
    localparam logic [2:0] FN_BUILD = 3'd3;
    localparam logic [2:0] FN_BASE  = 3'd4;
    localparam logic [2:0] FN_READ  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] value;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [8:0] palette_size;
        logic [8:0] ramp_length;
    } out_word_t;
endpackage

// ===== rtl/srpb_if.sv =====
// Valid/ready channel interface carrying one word of a given type.
// Depends on srpb_pkg for the word types.
interface srpb_in_if;
    logic valid;
    logic ready;
    srpb_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srpb_out_if;
    logic valid;
    logic ready;
    srpb_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/shading_ramp_palette_builder_unit.sv =====
// Shading ramp palette builder top level.
// Depends on srpb_pkg and the channel interfaces in srpb_if.
// Find scans the colours in order, and ramp base adds a base memory read after the match.
// Build with ramps of two or more runs three step divisions per colour, with at most 128 colours;
// with a ramp of one or less (more than 128 colours) build copies the colours instead.
// One word at a time: the next word is accepted the cycle after the result is taken.
// Reset clears the counts and, by stepping through every entry, the palette and base memories.
module shading_ramp_palette_builder_unit (
    input  logic clk,
    input  logic rst_n,
    srpb_in_if.sink   in_ch,
    srpb_out_if.source out_ch
);
    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2,
        S_SCANW = 4'd3, S_BASE = 4'd4, S_READ = 4'd5, S_DIV = 4'd6,
        S_CRD = 4'd7, S_CDIV = 4'd8, S_FILL = 4'd9, S_COPY = 4'd10,
        S_COPYW = 4'd11, S_OUT = 4'd12, S_READW = 4'd13, S_BASEW = 4'd14;

    logic [23:0] colour_mem [srpb_pkg::ENTRIES];
    logic [23:0] pal_mem [srpb_pkg::ENTRIES];
    logic [7:0]  base_mem [srpb_pkg::ENTRIES];

    logic [3:0] state_reg;
    logic [8:0] count_reg, size_reg, ramp_reg;
    srpb_pkg::in_word_t cmd_reg;
    srpb_pkg::out_word_t res_reg;
    logic [8:0] i_reg, pos_reg, j_reg;
    logic [23:0] crd_reg, prd_reg;
    logic [7:0]  brd_reg;
    logic [15:0] rem_reg, quo_reg;
    logic [8:0]  div_reg;
    logic [4:0]  bit_reg;
    logic [15:0] dr_reg, dg_reg, db_reg, ar_reg, ag_reg, ab_reg;
    logic [1:0]  ch_reg;
    logic [8:0]  rq_reg;

    logic        c_we, p_we, b_we;
    logic [7:0]  c_wa, p_wa, b_wa, c_ra, p_ra, b_ra;
    logic [23:0] c_wd, p_wd;
    logic [7:0]  b_wd;

    srpb_pkg::out_word_t start_res;
    logic [3:0] start_state;

    always_ff @(posedge clk)
    begin
        if (c_we) colour_mem[c_wa] <= c_wd;
        if (p_we) pal_mem[p_wa] <= p_wd;
        if (b_we) base_mem[b_wa] <= b_wd;
        crd_reg <= colour_mem[c_ra];
        prd_reg <= pal_mem[p_ra];
        brd_reg <= base_mem[b_ra];
    end

    logic [16:0] trial;
    logic [7:0] chan;
    assign trial = {rem_reg, quo_reg[15]} - {8'd0, div_reg};
    assign chan = (ch_reg == 2'd0) ? crd_reg[23:16] :
                  (ch_reg == 2'd1) ? crd_reg[15:8] : crd_reg[7:0];

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = res_reg;

    always_comb
    begin
        start_res = '0;
        start_res.palette_size = size_reg;
        start_res.ramp_length = ramp_reg;
        start_state = S_OUT;
        unique case (in_ch.data.func)
            srpb_pkg::FN_ADD:
                if (count_reg[8]) start_res.status = srpb_pkg::ST_FULL;
            srpb_pkg::FN_FIND, srpb_pkg::FN_BASE: start_state = S_SCAN;
            srpb_pkg::FN_BUILD:
                if (count_reg == 9'd0) start_res.status = srpb_pkg::ST_NONE;
                else start_state = S_DIV;
            srpb_pkg::FN_READ: start_state = S_READW;
            default: ;
        endcase
    end

    always_comb
    begin
        c_we = 1'b0; c_wa = count_reg[7:0]; c_wd = {in_ch.data.red,
            in_ch.data.green, in_ch.data.blue};
        p_we = 1'b0; p_wa = pos_reg[7:0]; p_wd = {ar_reg[15:8], ag_reg[15:8], ab_reg[15:8]};
        b_we = 1'b0; b_wa = i_reg[7:0]; b_wd = pos_reg[7:0];
        c_ra = i_reg[7:0]; p_ra = cmd_reg.entry_index; b_ra = i_reg[7:0];
        unique case (state_reg)
            S_INIT:
            begin
                p_we = 1'b1; p_wa = i_reg[7:0]; p_wd = 24'd0;
                b_we = 1'b1; b_wd = 8'd0;
            end
            S_IDLE:
                c_we = in_ch.valid && (in_ch.data.func == srpb_pkg::FN_ADD)
                    && !count_reg[8];
            S_FILL:
            begin
                p_we = 1'b1;
                b_we = (j_reg == 9'd0);
            end
            S_COPYW:
            begin
                p_we = 1'b1; p_wa = i_reg[7:0]; p_wd = crd_reg;
                b_we = 1'b1; b_wd = i_reg[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= '0; size_reg <= '0; ramp_reg <= '0; i_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    i_reg <= i_reg + 9'd1;
                    if (i_reg == 9'd255) state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        cmd_reg <= in_ch.data;
                        res_reg <= start_res;
                        i_reg <= '0;
                        pos_reg <= '0;
                        rem_reg <= '0; quo_reg <= 16'd256;
                        div_reg <= count_reg; bit_reg <= 5'd16;
                        state_reg <= start_state;
                        if (in_ch.data.func == srpb_pkg::FN_CLEAR) count_reg <= '0;
                        else if (in_ch.data.func == srpb_pkg::FN_ADD && !count_reg[8])
                            count_reg <= count_reg + 9'd1;
                    end
                S_SCAN:
                    if (i_reg >= count_reg)
                    begin
                        res_reg.status <= srpb_pkg::ST_NONE;
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_SCANW;
                S_SCANW:
                    if (crd_reg == {cmd_reg.red, cmd_reg.green, cmd_reg.blue})
                    begin
                        if (cmd_reg.func == srpb_pkg::FN_FIND)
                        begin
                            res_reg.value <= i_reg;
                            state_reg <= S_OUT;
                        end
                        else state_reg <= S_BASEW;
                    end
                    else
                    begin
                        i_reg <= i_reg + 9'd1;
                        state_reg <= S_SCAN;
                    end
                S_BASEW: state_reg <= S_BASE;
                S_BASE:
                begin
                    res_reg.value <= {1'b0, brd_reg};
                    state_reg <= S_OUT;
                end
                S_READW: state_reg <= S_READ;
                S_READ:
                begin
                    {res_reg.entry_red, res_reg.entry_green, res_reg.entry_blue} <= prd_reg;
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (!trial[16]) rem_reg <= trial[15:0];
                    else rem_reg <= {rem_reg[14:0], quo_reg[15]};
                    quo_reg <= {quo_reg[14:0], !trial[16]};
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd1)
                    begin
                        rq_reg <= {quo_reg[7:0], !trial[16]};
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    ramp_reg <= rq_reg;
                    res_reg.ramp_length <= rq_reg;
                    if (rq_reg <= 9'd1) state_reg <= S_COPY;
                    else if (i_reg >= count_reg || pos_reg[8])
                    begin
                        size_reg <= pos_reg;
                        res_reg.value <= pos_reg;
                        res_reg.palette_size <= pos_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ch_reg <= 2'd0; bit_reg <= 5'd16;
                        state_reg <= S_CDIV;
                    end
                end
                S_CDIV:
                begin
                    if (bit_reg == 5'd16)
                    begin
                        rem_reg <= '0; quo_reg <= {chan, 8'd0};
                        div_reg <= rq_reg - 9'd1;
                        bit_reg <= 5'd15;
                    end
                    else
                    begin
                        if (!trial[16]) rem_reg <= trial[15:0];
                        else rem_reg <= {rem_reg[14:0], quo_reg[15]};
                        quo_reg <= {quo_reg[14:0], !trial[16]};
                        if (bit_reg == 5'd0)
                        begin
                            unique case (ch_reg)
                                2'd0: dr_reg <= {quo_reg[14:0], !trial[16]};
                                2'd1: dg_reg <= {quo_reg[14:0], !trial[16]};
                                default: db_reg <= {quo_reg[14:0], !trial[16]};
                            endcase
                            bit_reg <= 5'd16;
                            if (ch_reg == 2'd2)
                            begin
                                ar_reg <= '0; ag_reg <= '0; ab_reg <= '0;
                                j_reg <= '0;
                                state_reg <= S_FILL;
                            end
                            else ch_reg <= ch_reg + 2'd1;
                        end
                        else bit_reg <= bit_reg - 5'd1;
                    end
                end
                S_FILL:
                begin
                    pos_reg <= pos_reg + 9'd1;
                    j_reg <= j_reg + 9'd1;
                    ar_reg <= ar_reg + dr_reg;
                    ag_reg <= ag_reg + dg_reg;
                    ab_reg <= ab_reg + db_reg;
                    if (j_reg + 9'd1 >= rq_reg || pos_reg == 9'd255)
                    begin
                        i_reg <= i_reg + 9'd1;
                        state_reg <= S_CRD;
                    end
                end
                S_COPY:
                    if (i_reg >= count_reg)
                    begin
                        size_reg <= count_reg;
                        res_reg.value <= count_reg;
                        res_reg.palette_size <= count_reg;
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_COPYW;
                S_COPYW:
                begin
                    i_reg <= i_reg + 9'd1;
                    state_reg <= S_COPY;
                end
                S_OUT:
                    if (out_ch.ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
